### hdl/sms_pkg.sv
// Shared constants, types and state codes for the stable merge sorter.
// Used by sms_cmp and stable_merge_sorter; depends on nothing.
`timescale 1ns / 1ps

package sms_pkg;

  localparam int MAX_ELEMENTS = 64;
  localparam int KEY_WIDTH    = 32;
  localparam int PORT_WIDTH   = 32;
  localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int MODE_W       = 2;

  // Bit positions inside compare_mode.
  localparam int MODE_SIGNED_BIT = 0;
  localparam int MODE_DESC_BIT   = 1;

  typedef logic [KEY_WIDTH-1:0] key_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [CNT_W:0]       cnt_wide_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [MODE_W-1:0]    mode_t;

  typedef enum logic [5:0] {
    ST_LOAD      = 6'b000001,
    ST_SETUP     = 6'b000010,
    ST_READ      = 6'b000100,
    ST_MERGE     = 6'b001000,
    ST_EMIT_WAIT = 6'b010000,
    ST_EMIT_RD   = 6'b100000
  } seq_state_t;

endpackage

### hdl/sms_ram.sv
// Generic memory: one write port, two read ports with registered read data.
// Stand-alone; no package needed.
`timescale 1ns / 1ps

module sms_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### hdl/sms_cmp.sv
// Shared key comparator: maps both keys to the selected order, then compares.
// Depends on sms_pkg.
`timescale 1ns / 1ps

module sms_cmp (
  input  sms_pkg::key_t  key_a,
  input  sms_pkg::key_t  key_b,
  input  sms_pkg::mode_t mode,
  output logic           a_first
);

  sms_pkg::key_t ord_a;
  sms_pkg::key_t ord_b;
  sms_pkg::key_t flip;

  always_comb begin
    flip = '0;
    // Flip the sign bit for signed order, all bits for descending order.
    if (mode[sms_pkg::MODE_SIGNED_BIT]) begin
      flip[sms_pkg::KEY_WIDTH-1] = 1'b1;
    end
    ord_a = key_a ^ flip;
    ord_b = key_b ^ flip;
    if (mode[sms_pkg::MODE_DESC_BIT]) begin
      ord_a = ~ord_a;
      ord_b = ~ord_b;
    end
    // Equal keys favor the left run, which keeps the sort stable.
    a_first = (ord_a <= ord_b);
  end

endmodule

### hdl/stable_merge_sorter.sv
// Top level of the stable merge sorter: sequencer, ping-pong stores, result register.
// Depends on sms_pkg, sms_ram and sms_cmp.
//
// Usage:
//   Keys arrive on the load channel (load_valid / load_stall, key_in, last_in), one word per
//   cycle while the block is loading. A word with last_in high closes the set; up to 64 keys
//   are kept, later keys of an over-full set are dropped but their last_in still closes it.
//   The block then sorts with bottom-up merge passes (run width 1, 2, 4, ...) through one
//   shared comparator, alternating between two stores so no copy pass is needed. Equal keys
//   keep their arrival order. Each merged key passes through a read state and a merge state
//   (compare and write), and each run pair through the setup state. Load_stall stays high
//   from the closing word until the final sorted word is in the result register.
//   Sorted words leave on the result channel (result_valid / result_stall, key_out,
//   last_out), each one read and then loaded into the result register; last_out marks the
//   final word. A stalled word holds in the result register and the sequencer waits.
//   Compare_mode is written through cfg_valid / cfg_ready / cfg_data: 0 unsigned ascending,
//   1 signed ascending, 2 unsigned descending, 3 signed descending. The user must write it
//   only while idle; the block does not enforce this. Synchronous reset clears the count,
//   the mode and the result register and returns the block to loading. Store contents are
//   not cleared; only written entries are ever read.
`timescale 1ns / 1ps

module stable_merge_sorter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sms_pkg::MODE_W-1:0]      cfg_data,
  input  logic                            load_valid,
  output logic                            load_stall,
  input  logic [sms_pkg::PORT_WIDTH-1:0]  key_in,
  input  logic                            last_in,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [sms_pkg::PORT_WIDTH-1:0]  key_out,
  output logic                            last_out
);

  sms_pkg::seq_state_t state;
  sms_pkg::mode_t      mode;
  sms_pkg::cnt_t       count;
  sms_pkg::cnt_t       width;
  sms_pkg::cnt_t       lo;
  sms_pkg::cnt_t       mid;
  sms_pkg::cnt_t       hi;
  sms_pkg::cnt_t       idx_i;
  sms_pkg::cnt_t       idx_j;
  sms_pkg::cnt_t       idx_k;
  logic                sel;        // store that holds the current data

  // Memory ports
  logic          we0;
  logic          we1;
  sms_pkg::addr_t waddr;
  sms_pkg::key_t  wdata;
  sms_pkg::addr_t raddr_a;
  sms_pkg::addr_t raddr_b;
  sms_pkg::key_t  r0_a;
  sms_pkg::key_t  r0_b;
  sms_pkg::key_t  r1_a;
  sms_pkg::key_t  r1_b;
  sms_pkg::key_t  rd_a;
  sms_pkg::key_t  rd_b;

  logic load_acc;
  logic load_we;
  logic merge_we;
  logic a_first;
  logic take_left;
  logic out_free;
  logic emit_fire;

  sms_pkg::cnt_wide_t cnt_loaded;
  sms_pkg::cnt_wide_t lo_plus_w;
  sms_pkg::cnt_wide_t lo_plus_2w;
  sms_pkg::cnt_wide_t width_dbl;
  sms_pkg::cnt_t      k_inc;

  assign cfg_ready  = 1'b1;
  assign load_stall = (state != sms_pkg::ST_LOAD);
  assign load_acc   = load_valid && !load_stall;
  assign out_free   = !result_valid || !result_stall;
  assign emit_fire  = (state == sms_pkg::ST_EMIT_RD) && out_free;

  // Drop keys once the store is full.
  assign load_we  = load_acc && (count < sms_pkg::CNT_W'(sms_pkg::MAX_ELEMENTS));
  assign merge_we = (state == sms_pkg::ST_MERGE);

  assign we0 = (load_we && !sel) || (merge_we && sel);
  assign we1 = (load_we && sel) || (merge_we && !sel);

  assign take_left = (idx_i < mid) && ((idx_j >= hi) || a_first);

  assign waddr = load_we ? count[sms_pkg::ADDR_W-1:0] : idx_k[sms_pkg::ADDR_W-1:0];
  assign wdata = load_we ? sms_pkg::KEY_WIDTH'(key_in) : (take_left ? rd_a : rd_b);

  // Port A walks the left run (or the emit index), port B the right run.
  assign raddr_a = (state == sms_pkg::ST_READ) ? idx_i[sms_pkg::ADDR_W-1:0]
                                               : idx_k[sms_pkg::ADDR_W-1:0];
  assign raddr_b = idx_j[sms_pkg::ADDR_W-1:0];

  assign rd_a = sel ? r1_a : r0_a;
  assign rd_b = sel ? r1_b : r0_b;

  assign cnt_loaded = {1'b0, count} + sms_pkg::cnt_wide_t'(load_we);
  assign lo_plus_w  = {1'b0, lo} + {1'b0, width};
  assign lo_plus_2w = {1'b0, lo} + {width, 1'b0};
  assign width_dbl  = {width, 1'b0};
  assign k_inc      = idx_k + sms_pkg::CNT_W'(1);

  sms_ram #(
    .DEPTH (sms_pkg::MAX_ELEMENTS),
    .WIDTH (sms_pkg::KEY_WIDTH)
  ) u_store0 (
    .clk     (clk),
    .we      (we0),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .rdata_a (r0_a),
    .raddr_b (raddr_b),
    .rdata_b (r0_b)
  );

  sms_ram #(
    .DEPTH (sms_pkg::MAX_ELEMENTS),
    .WIDTH (sms_pkg::KEY_WIDTH)
  ) u_store1 (
    .clk     (clk),
    .we      (we1),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .rdata_a (r1_a),
    .raddr_b (raddr_b),
    .rdata_b (r1_b)
  );

  sms_cmp u_cmp (
    .key_a   (rd_a),
    .key_b   (rd_b),
    .mode    (mode),
    .a_first (a_first)
  );

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= '0;
    end else if (cfg_valid && cfg_ready) begin
      mode <= cfg_data;
    end
  end

  // Result valid: set when a sorted word is loaded, drop once the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit_fire) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= sms_pkg::ST_LOAD;
      count        <= '0;
      sel          <= 1'b0;
      width        <= '0;
      lo           <= '0;
      mid          <= '0;
      hi           <= '0;
      idx_i        <= '0;
      idx_j        <= '0;
      idx_k        <= '0;
      key_out      <= '0;
      last_out     <= 1'b0;
    end else begin
      unique case (state)
        sms_pkg::ST_LOAD: begin
          if (load_acc) begin
            count <= cnt_loaded[sms_pkg::CNT_W-1:0];
            if (last_in) begin
              width <= sms_pkg::CNT_W'(1);
              lo    <= '0;
              idx_k <= '0;
              // A single key needs no merge pass.
              if (cnt_loaded <= sms_pkg::cnt_wide_t'(1)) begin
                state <= sms_pkg::ST_EMIT_WAIT;
              end else begin
                state <= sms_pkg::ST_SETUP;
              end
            end
          end
        end

        sms_pkg::ST_SETUP: begin
          // Bound both runs of this pair by the set size.
          mid   <= (lo_plus_w < {1'b0, count}) ? lo_plus_w[sms_pkg::CNT_W-1:0] : count;
          hi    <= (lo_plus_2w < {1'b0, count}) ? lo_plus_2w[sms_pkg::CNT_W-1:0] : count;
          idx_i <= lo;
          idx_j <= (lo_plus_w < {1'b0, count}) ? lo_plus_w[sms_pkg::CNT_W-1:0] : count;
          idx_k <= lo;
          state <= sms_pkg::ST_READ;
        end

        sms_pkg::ST_READ: begin
          state <= sms_pkg::ST_MERGE;
        end

        sms_pkg::ST_MERGE: begin
          // Write the winner to the other store and advance its run.
          if (take_left) begin
            idx_i <= idx_i + sms_pkg::CNT_W'(1);
          end else begin
            idx_j <= idx_j + sms_pkg::CNT_W'(1);
          end
          if (k_inc == hi) begin
            if (lo_plus_2w >= {1'b0, count}) begin
              // Pass done: the other store now holds the data.
              sel <= !sel;
              if (width_dbl >= {1'b0, count}) begin
                idx_k <= '0;
                state <= sms_pkg::ST_EMIT_WAIT;
              end else begin
                width <= width_dbl[sms_pkg::CNT_W-1:0];
                lo    <= '0;
                state <= sms_pkg::ST_SETUP;
              end
            end else begin
              lo    <= lo_plus_2w[sms_pkg::CNT_W-1:0];
              state <= sms_pkg::ST_SETUP;
            end
          end else begin
            idx_k <= k_inc;
            state <= sms_pkg::ST_READ;
          end
        end

        sms_pkg::ST_EMIT_WAIT: begin
          // Address idx_k sits on port A; its data is ready next cycle.
          state <= sms_pkg::ST_EMIT_RD;
        end

        sms_pkg::ST_EMIT_RD: begin
          // Read data for idx_k is valid here; hold until the result register frees up.
          if (out_free) begin
            key_out      <= sms_pkg::PORT_WIDTH'(rd_a);
            last_out     <= (k_inc == count);
            if (k_inc == count) begin
              count <= '0;
              state <= sms_pkg::ST_LOAD;
            end else begin
              idx_k <= k_inc;
              state <= sms_pkg::ST_EMIT_WAIT;
            end
          end
        end

        default: begin
          state <= sms_pkg::ST_LOAD;
        end
      endcase
    end
  end

endmodule
